/* hw/rtl/urb_pkg.sv */
// Shared types, constants and helpers for the 16550-style register block.
// No dependencies.
package urb_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = $clog2(2 * FIFO_DEPTH) + 1;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RX    = 2'd2
    } func_t;

    localparam logic [2:0] OFS_DATA = 3'd0;
    localparam logic [2:0] OFS_IER  = 3'd1;
    localparam logic [2:0] OFS_IIR  = 3'd2;
    localparam logic [2:0] OFS_LCR  = 3'd3;
    localparam logic [2:0] OFS_MCR  = 3'd4;
    localparam logic [2:0] OFS_LSR  = 3'd5;
    localparam logic [2:0] OFS_MSR  = 3'd6;
    localparam logic [2:0] OFS_SCR  = 3'd7;

    localparam logic [7:0] IIR_OVERRUN = 8'h06;
    localparam logic [7:0] IIR_RX_DATA = 8'h04;
    localparam logic [7:0] IIR_THRE    = 8'h02;
    localparam logic [7:0] IIR_NONE    = 8'h01;
    localparam logic [7:0] IIR_FIFO_ON = 8'hC0;
    localparam logic [7:0] LSR_FIXED   = 8'h60;

    localparam int LCR_DLAB_BIT = 7;
    localparam int MCR_DTR_BIT  = 0;
    localparam int MCR_RTS_BIT  = 1;
    localparam int MCR_OUT1_BIT = 2;
    localparam int MCR_OUT2_BIT = 3;
    localparam int MCR_LOOP_BIT = 4;
    localparam int IER_RDA_BIT  = 0;
    localparam int IER_THRE_BIT = 1;
    localparam int IER_RLS_BIT  = 2;

    typedef struct packed {
        logic       valid;
        logic       use_mem;
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
    } stage_t;

    function automatic logic [FILL_W-1:0] trigger_level(input logic fifo_en,
                                                        input logic [1:0] sel);
        int lvl;
        case (sel)
            2'd0:    lvl = 1;
            2'd1:    lvl = 4;
            2'd2:    lvl = 8;
            default: lvl = 14;
        endcase
        if (!fifo_en)
            lvl = 1;
        else if (lvl > FIFO_DEPTH)
            lvl = FIFO_DEPTH;
        return FILL_W'(lvl);
    endfunction

    function automatic logic [7:0] pending_id(input logic [3:0]        ier,
                                              input logic              overrun,
                                              input logic [FILL_W-1:0] fill,
                                              input logic              fifo_en,
                                              input logic [1:0]        sel,
                                              input logic              thre);
        logic [7:0] id;
        if (ier[IER_RLS_BIT] && overrun)
            id = IIR_OVERRUN;
        else if (ier[IER_RDA_BIT] && (fill != '0) && (fill >= trigger_level(fifo_en, sel)))
            id = IIR_RX_DATA;
        else if (ier[IER_THRE_BIT] && thre)
            id = IIR_THRE;
        else
            id = IIR_NONE;
        return id;
    endfunction

endpackage

/* hw/rtl/urb_req_if.sv */
// Request channel: bus access or received byte, valid/ready handshake.
// Depends on nothing.
interface urb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [2:0] offset;
    logic [7:0] wdata;
    logic [7:0] rx_byte;

    modport source (output valid, func, offset, wdata, rx_byte, input ready);
    modport sink   (input valid, func, offset, wdata, rx_byte, output ready);
endinterface

/* hw/rtl/urb_rsp_if.sv */
// Response channel: read data, transmit byte and interrupt line.
// Depends on nothing.
interface urb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;

    modport source (output valid, rdata, tx_valid, tx_byte, irq, input ready);
    modport sink   (input valid, rdata, tx_valid, tx_byte, irq, output ready);
endinterface

/* hw/rtl/urb_rx_ram.sv */
// Receive FIFO storage: one write port, one read port, registered read data.
// No dependencies.
module urb_rx_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/uart_16550_register_block_core.sv */
// 16550-style register block: control registers plus receive FIFO in RAM.
// Depends on urb_pkg, urb_req_if, urb_rsp_if and urb_rx_ram.
// An accepted request is registered in the s1 stage, then in the response register that drives rsp.
// Throughput: one request per cycle while the response sink is ready; the RAM read
// issued at accept lands in the second stage, and the response register decouples a stalled sink.
// Reset (rst_n low, async): all registers zero, FIFO empty, no response held.
module uart_16550_register_block_core (
    input  logic clk,
    input  logic rst_n,
    urb_req_if.sink   req,
    urb_rsp_if.source rsp
);
    import urb_pkg::*;

    logic [15:0]       dll_reg, dll_next;
    logic [3:0]        ier_reg, ier_next;
    logic [7:0]        lcr_reg, lcr_next;
    logic [4:0]        mcr_reg, mcr_next;
    logic              fifo_en_reg, fifo_en_next;
    logic [1:0]        trig_sel_reg, trig_sel_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              overrun_reg, overrun_next;
    logic              thre_reg, thre_next;

    stage_t s1_reg, s1_next;
    stage_t out_reg, out_next;

    logic              accept;
    logic              s1_adv;
    logic              dlab;
    logic              loopback;
    logic [FILL_W-1:0] capacity;
    logic              push_req;
    logic [7:0]        push_byte;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  wsum;
    logic [7:0]        mem_rdata;
    logic [7:0]        rd_val;
    logic              rd_mem;
    logic              tx_v;
    logic [7:0]        tx_b;
    logic [7:0]        iir_id;

    assign s1_adv    = s1_reg.valid && (!out_reg.valid || rsp.ready);
    assign req.ready = !s1_reg.valid || s1_adv;
    assign accept    = req.valid && req.ready;

    assign dlab     = lcr_reg[LCR_DLAB_BIT];
    assign loopback = mcr_reg[MCR_LOOP_BIT];
    assign capacity = fifo_en_reg ? FILL_W'(FIFO_DEPTH) : FILL_W'(1);
    assign iir_id   = pending_id(ier_reg, overrun_reg, fill_reg, fifo_en_reg,
                                 trig_sel_reg, thre_reg);

    assign wsum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign waddr = (wsum >= SUM_W'(FIFO_DEPTH)) ? ADDR_W'(wsum - SUM_W'(FIFO_DEPTH))
                                                : ADDR_W'(wsum);

    always_comb
    begin
        dll_next      = dll_reg;
        ier_next      = ier_reg;
        lcr_next      = lcr_reg;
        mcr_next      = mcr_reg;
        fifo_en_next  = fifo_en_reg;
        trig_sel_next = trig_sel_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        overrun_next  = overrun_reg;
        thre_next     = thre_reg;
        push_req      = 1'b0;
        push_byte     = req.wdata;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_val        = 8'h00;
        rd_mem        = 1'b0;
        tx_v          = 1'b0;
        tx_b          = 8'h00;

        if (accept)
        begin
            case (req.func)
                FUNC_READ:
                begin
                    case (req.offset)
                        OFS_DATA:
                        begin
                            if (dlab)
                            begin
                                rd_val = dll_reg[7:0];
                            end
                            else if (fill_reg != '0)
                            begin
                                rd_mem    = 1'b1;
                                mem_re    = 1'b1;
                                head_next = (head_reg == ADDR_W'(FIFO_DEPTH - 1)) ? '0
                                                                                 : head_reg + 1'b1;
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OFS_IER:
                        begin
                            rd_val = dlab ? dll_reg[15:8] : {4'b0000, ier_reg};
                        end
                        OFS_IIR:
                        begin
                            if (iir_id == IIR_THRE)
                            begin
                                thre_next = 1'b0;
                            end
                            rd_val = iir_id | (fifo_en_reg ? IIR_FIFO_ON : 8'h00);
                        end
                        OFS_LCR: rd_val = lcr_reg;
                        OFS_MCR: rd_val = {3'b000, mcr_reg};
                        OFS_LSR:
                        begin
                            rd_val       = LSR_FIXED | {6'b0, overrun_reg, fill_reg != '0};
                            overrun_next = 1'b0;
                        end
                        OFS_MSR:
                        begin
                            if (loopback)
                            begin
                                rd_val = {mcr_reg[MCR_OUT2_BIT], mcr_reg[MCR_OUT1_BIT],
                                          mcr_reg[MCR_DTR_BIT], mcr_reg[MCR_RTS_BIT], 4'b0000};
                            end
                        end
                        default: rd_val = 8'h00;
                    endcase
                end
                FUNC_WRITE:
                begin
                    case (req.offset)
                        OFS_DATA:
                        begin
                            if (dlab)
                            begin
                                dll_next[7:0] = req.wdata;
                            end
                            else
                            begin
                                thre_next = 1'b1;
                                if (loopback)
                                begin
                                    push_req = 1'b1;
                                end
                                else
                                begin
                                    tx_v = 1'b1;
                                    tx_b = req.wdata;
                                end
                            end
                        end
                        OFS_IER:
                        begin
                            if (dlab)
                            begin
                                dll_next[15:8] = req.wdata;
                            end
                            else
                            begin
                                ier_next = req.wdata[3:0];
                                if (req.wdata[IER_THRE_BIT])
                                begin
                                    thre_next = 1'b1;
                                end
                            end
                        end
                        OFS_IIR:
                        begin
                            if ((req.wdata[0] != fifo_en_reg) || req.wdata[1])
                            begin
                                head_next = '0;
                                fill_next = '0;
                            end
                            fifo_en_next = req.wdata[0];
                            if (req.wdata[0])
                            begin
                                trig_sel_next = req.wdata[7:6];
                            end
                        end
                        OFS_LCR: lcr_next = req.wdata;
                        OFS_MCR: mcr_next = req.wdata[4:0];
                        default: ;
                    endcase
                end
                FUNC_RX:
                begin
                    if (!loopback)
                    begin
                        push_req  = 1'b1;
                        push_byte = req.rx_byte;
                    end
                end
                default: ;
            endcase

            if (push_req)
            begin
                if (fill_reg >= capacity)
                begin
                    overrun_next = 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (accept)
        begin
            s1_next.valid    = 1'b1;
            s1_next.use_mem  = rd_mem;
            s1_next.rdata    = rd_val;
            s1_next.tx_valid = tx_v;
            s1_next.tx_byte  = tx_b;
            s1_next.irq      = (pending_id(ier_next, overrun_next, fill_next, fifo_en_next,
                                           trig_sel_next, thre_next) != IIR_NONE)
                               && mcr_next[MCR_OUT2_BIT];
        end
        else if (s1_adv)
        begin
            s1_next.valid = 1'b0;
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (s1_adv)
        begin
            out_next         = s1_reg;
            out_next.use_mem = 1'b0;
            out_next.rdata   = s1_reg.use_mem ? mem_rdata : s1_reg.rdata;
        end
        else if (rsp.ready)
        begin
            out_next.valid = 1'b0;
        end
    end

    urb_rx_ram #(
        .DEPTH  (FIFO_DEPTH),
        .WIDTH  (8),
        .ADDR_W (ADDR_W)
    ) u_rx_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (push_byte),
        .re    (mem_re),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dll_reg      <= '0;
            ier_reg      <= '0;
            lcr_reg      <= '0;
            mcr_reg      <= '0;
            fifo_en_reg  <= 1'b0;
            trig_sel_reg <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            overrun_reg  <= 1'b0;
            thre_reg     <= 1'b0;
            s1_reg       <= '0;
            out_reg      <= '0;
        end
        else
        begin
            dll_reg      <= dll_next;
            ier_reg      <= ier_next;
            lcr_reg      <= lcr_next;
            mcr_reg      <= mcr_next;
            fifo_en_reg  <= fifo_en_next;
            trig_sel_reg <= trig_sel_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            overrun_reg  <= overrun_next;
            thre_reg     <= thre_next;
            s1_reg       <= s1_next;
            out_reg      <= out_next;
        end
    end

    assign rsp.valid    = out_reg.valid;
    assign rsp.rdata    = out_reg.rdata;
    assign rsp.tx_valid = out_reg.tx_valid;
    assign rsp.tx_byte  = out_reg.tx_byte;
    assign rsp.irq      = out_reg.irq;
endmodule

/* hw/rtl/urb_checker.sv */
// Port-level checks for the register block, attached by bind.
// Depends on uart_16550_register_block_core.
module urb_port_checks (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_rdata,
    input logic       rsp_tx_valid,
    input logic [7:0] rsp_tx_byte,
    input logic       rsp_irq
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata) && $stable(rsp_tx_valid)
                                    && $stable(rsp_tx_byte) && $stable(rsp_irq))
        else $error("response changed while stalled");

    a_rsp_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without matching request");

    a_tx_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_tx_valid |-> rsp_rdata == 8'h00)
        else $error("transmit response carries read data");

    a_tx_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'h00)
        else $error("transmit byte set without transmit");
endmodule

bind uart_16550_register_block_core urb_port_checks u_urb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_rdata    (rsp.rdata),
    .rsp_tx_valid (rsp.tx_valid),
    .rsp_tx_byte  (rsp.tx_byte),
    .rsp_irq      (rsp.irq)
);
